// ===== src/ssi_pkg.sv =====
// ssi_pkg: sizes, field widths and shared types of the stable sort core
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

	// store depth and key width
	localparam int DEPTH  = 64;
	localparam int KEY_W  = 32;
	// field width of the arrival position on the result channel
	localparam int POS_W  = 7;
	// derived sizes
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// controller state, one-hot
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_FEED  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DRAIN = 4'b1000
	} ssi_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              pop;
		logic              pop_last;
		logic              pop_ovf;
	} ssi_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
	} ssi_sts_t;

endpackage

`default_nettype wire

// ===== src/ssi_in_if.sv =====
// ssi_in_if: request channel carrying one key of the vector
// depends on ssi_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ssi_in_if
	import ssi_pkg::*;
;
	logic              valid;
	logic              ready;
	logic signed [31:0] key_value;
	logic              last_item;

	modport source (output valid, output key_value, output last_item, input ready);
	modport sink (input valid, input key_value, input last_item, output ready);
endinterface

`default_nettype wire

// ===== src/ssi_out_if.sv =====
// ssi_out_if: result channel carrying one sorted key with its position
// depends on ssi_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ssi_out_if
	import ssi_pkg::*;
;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_value;
	logic [POS_W-1:0]   original_position;
	logic               last_result;
	logic               overflow;

	modport source (output valid, output sorted_value, output original_position,
		output last_result, output overflow, input ready);
	modport sink (input valid, input sorted_value, input original_position,
		input last_result, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/ssi_cfg_if.sv =====
// ssi_cfg_if: write channel for the sort direction register
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ssi_cfg_if;
	logic valid;
	logic ready;
	logic descending;

	modport source (output valid, output descending, input ready);
	modport sink (input valid, input descending, output ready);
endinterface

`default_nettype wire

// ===== src/ssi_ctrl.sv =====
// ssi_ctrl: state machine and counters of the stable sort core
// depends on ssi_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssi_ctrl
	import ssi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	input  wire ssi_sts_t sts,
	output ssi_cmd_t      cmd
);

	ssi_state_t        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] feed_idx_q;
	logic              ovf_q;
	logic              in_acc;
	logic              room;
	logic              feed_done;
	logic              pop;

	// handshake and decode
	assign in_ready  = (state_q == ST_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign room      = (cnt_q < CNT_W'(DEPTH));
	assign feed_done = ((CNT_W'(feed_idx_q) + CNT_W'(1)) == cnt_q);
	assign pop       = (state_q == ST_DRAIN) && sts.out_free;

	// commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.wr_en    = in_acc && room;
		cmd.wr_addr  = cnt_q[ADDR_W-1:0];
		cmd.rd_en    = (state_q == ST_FEED);
		cmd.rd_addr  = feed_idx_q;
		cmd.pop      = pop;
		cmd.pop_last = (cnt_q == CNT_W'(1));
		cmd.pop_ovf  = ovf_q;
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			feed_idx_q <= '0;
			ovf_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							feed_idx_q <= '0;
							state_q    <= ST_FEED;
						end
					end
				end
				ST_FEED: begin
					// one stored key read per cycle into the insertion chain
					feed_idx_q <= feed_idx_q + ADDR_W'(1);
					if (feed_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// final key lands in the chain
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (pop) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/ssi_dpath.sv =====
// ssi_dpath: key store, insertion chain, output register and direction register
// depends on ssi_pkg, ssi_out_if, ssi_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module ssi_dpath
	import ssi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic signed [31:0] wr_key,
	input  wire ssi_cmd_t          cmd,
	output ssi_sts_t               sts,
	ssi_cfg_if.sink                cfg,
	ssi_out_if.source              results
);

	// key store
	logic [KEY_W-1:0]        mem [DEPTH];

	// read stage feeding the chain
	logic                    ins_s1;
	logic signed [KEY_W-1:0] ins_key_s1;
	logic [CNT_W-1:0]        ins_pos_s1;

	// insertion chain, kept sorted
	logic signed [KEY_W-1:0] ch_key_q [DEPTH];
	logic [CNT_W-1:0]        ch_pos_q [DEPTH];
	logic [DEPTH-1:0]        ch_vld_q;
	logic [DEPTH-1:0]        brk;

	// output register
	logic                    out_vld_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [CNT_W-1:0]        out_pos_q;
	logic                    out_last_q;
	logic                    out_ovf_q;

	logic                    desc_q;

	// direction register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg.valid) begin
			desc_q <= cfg.descending;
		end
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= KEY_W'(wr_key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			ins_key_s1 <= mem[cmd.rd_addr];
			ins_pos_s1 <= CNT_W'(cmd.rd_addr) + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_s1 <= 1'b0;
		end else begin
			ins_s1 <= cmd.rd_en;
		end
	end

	// cells where the new key goes strictly before the held key, or that are empty
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			brk[i] = !ch_vld_q[i] ||
				(desc_q ? (ins_key_s1 > ch_key_q[i]) : (ins_key_s1 < ch_key_q[i]));
		end
	end

	// chain payload: insert shifts right from the break point, pop shifts left
	always_ff @(posedge clk) begin
		if (ins_s1) begin
			if (brk[0]) begin
				ch_key_q[0] <= ins_key_s1;
				ch_pos_q[0] <= ins_pos_s1;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (brk[i]) begin
					if (brk[i-1]) begin
						ch_key_q[i] <= ch_key_q[i-1];
						ch_pos_q[i] <= ch_pos_q[i-1];
					end else begin
						ch_key_q[i] <= ins_key_s1;
						ch_pos_q[i] <= ins_pos_s1;
					end
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				ch_key_q[i] <= ch_key_q[i+1];
				ch_pos_q[i] <= ch_pos_q[i+1];
			end
		end
	end

	// chain occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_vld_q <= '0;
		end else if (ins_s1) begin
			ch_vld_q <= {ch_vld_q[DEPTH-2:0], 1'b1};
		end else if (cmd.pop) begin
			ch_vld_q <= {1'b0, ch_vld_q[DEPTH-1:1]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.pop) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_key_q  <= ch_key_q[0];
			out_pos_q  <= ch_pos_q[0];
			out_last_q <= cmd.pop_last;
			out_ovf_q  <= cmd.pop_ovf;
		end
	end

	assign sts.out_free = !out_vld_q || results.ready;

	assign results.valid             = out_vld_q;
	assign results.sorted_value      = 32'(out_key_q);
	assign results.original_position = POS_W'(out_pos_q);
	assign results.last_result       = out_last_q;
	assign results.overflow          = out_ovf_q;

endmodule

`default_nettype wire

// ===== src/stable_sort_with_index_core.sv =====
// stable_sort_with_index_core: top level of the stable sort with arrival index
// depends on ssi_pkg, ssi_in_if, ssi_out_if, ssi_cfg_if, ssi_ctrl, ssi_dpath
//
//   channel   dir   carries                                              per request
//   items     in    key_value, last_item                                 one key
//   results   out   sorted_value, original_position, last_result, overflow  one sorted key
//   cfg       in    descending                                           direction write
//
// keys load at one per cycle into a 64-entry store; the last key starts the sort
// during the sort, one store read per cycle feeds
// the insertion chain, then results leave at one per cycle while results.ready is high
// items.ready stays low from the last key until the final result enters the output register
// reset clears counters, chain occupancy, output valid and the direction (ascending)
`timescale 1ns / 1ps
`default_nettype none

module stable_sort_with_index_core
	import ssi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ssi_in_if.sink    items,
	ssi_out_if.source results,
	ssi_cfg_if.sink   cfg
);

	ssi_cmd_t cmd;
	ssi_sts_t sts;
	logic     in_ready;

	assign items.ready = in_ready;

	// controller
	ssi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_last  (items.last_item),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	ssi_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_key  (items.key_value),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg),
		.results (results)
	);

endmodule

`default_nettype wire
